@@ rtl/websocket_frame_decoder_defines.svh @@
// Assertion macros shared by the WebSocket frame decoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef WEBSOCKET_FRAME_DECODER_DEFINES_SVH
`define WEBSOCKET_FRAME_DECODER_DEFINES_SVH

// cond must never be true at a clock edge outside reset
`define WFD_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("wfd assertion failed: condition must never hold");

// ante at one edge implies cons at the next edge
`define WFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wfd assertion failed: expected consequence missing");

`endif

@@ rtl/wfd_pkg.sv @@
// Package for the WebSocket frame decoder: codes, reset values and the command type.
// No dependencies.
`default_nettype none

package wfd_pkg;

   // parse phases
   localparam logic [2:0] PH_HDR0 = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_EXT  = 3'd2;
   localparam logic [2:0] PH_MASK = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;

   // result events
   localparam logic [2:0] EV_BYTE    = 3'd0;
   localparam logic [2:0] EV_EMPTY   = 3'd1;
   localparam logic [2:0] EV_CLOSE   = 3'd2;
   localparam logic [2:0] EV_BADOP   = 3'd3;
   localparam logic [2:0] EV_TOOLONG = 3'd4;

   // frame kinds
   localparam logic [2:0] KIND_CONT = 3'd0;
   localparam logic [2:0] KIND_TEXT = 3'd1;
   localparam logic [2:0] KIND_BIN  = 3'd2;
   localparam logic [2:0] KIND_PING = 3'd3;
   localparam logic [2:0] KIND_PONG = 3'd4;

   // opcodes
   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   // 7-bit length escapes
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [2:0] MASK_BYTES  = 3'd4;

   // configuration registers
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVER_ROLE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_MSG     = 1'b1;
   localparam logic        SERVER_ROLE_RESET = 1'b0;
   localparam logic [31:0] MAX_MSG_RESET     = 32'd65536;

   localparam int WFD_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] data;
      logic [7:0] key;
      logic [2:0] frame_kind;
      logic       last_of_frame;
      logic       last_of_message;
   } wfd_cmd_type;

endpackage

`default_nettype wire

@@ rtl/wfd_parser.sv @@
// Front end: frame header parser, length check and per-byte command generation.
// Depends on wfd_pkg and websocket_frame_decoder_defines.svh.
`default_nettype none
`include "websocket_frame_decoder_defines.svh"

module wfd_parser
   import wfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        byte_valid,
   input  wire logic [7:0]  rx_byte,
   input  wire logic        server_role,
   input  wire logic [31:0] max_message_bytes,
   output wfd_cmd_type      cmd,
   output logic             cmd_push
);

   logic [2:0]  phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [2:0]  kind_ff, kind_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [63:0] len_ff, len_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] key_ff, key_in;
   logic [2:0]  mask_left_ff, mask_left_in;
   logic [32:0] acc_ff, acc_in;
   logic        halted_ff, halted_in;

   logic [63:0] new_len;
   logic [33:0] acc_sum;
   logic        too_long;
   logic        is_data;
   logic        len_done;
   logic        hdr_done;
   logic        last_byte;
   logic [7:0]  key_byte;
   logic        stop_ev;

   always_comb begin
      new_len = '0;
      if (phase_ff == PH_EXT) begin
         new_len = {len_ff[55:0], rx_byte};
      end else begin
         new_len = {57'd0, rx_byte[6:0]};
      end
   end

   assign is_data = (kind_ff == KIND_CONT) || (kind_ff == KIND_TEXT) || (kind_ff == KIND_BIN);
   assign acc_sum = {1'b0, acc_ff} + {1'b0, new_len[32:0]};
   assign too_long = is_data
      ? ((|new_len[63:33]) || (acc_sum > {2'b00, max_message_bytes}))
      : ((|new_len[63:32]) || (new_len[31:0] > max_message_bytes));

   assign last_byte = (len_ff == 64'd1);

   always_comb begin
      case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      if (!server_role) begin
         key_byte = 8'd0;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      fin_in       = fin_ff;
      kind_in      = kind_ff;
      ext_left_in  = ext_left_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      mask_left_in = mask_left_ff;
      acc_in       = acc_ff;
      halted_in    = halted_ff;
      len_done     = 1'b0;
      hdr_done     = 1'b0;
      cmd_push     = 1'b0;
      cmd          = '0;

      if (byte_valid && !halted_ff) begin
         case (phase_ff)
            PH_HDR1: begin
               len_in = '0;
               if (rx_byte[6:0] >= LEN7_EXT16) begin
                  ext_left_in = (rx_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  phase_in    = PH_EXT;
               end else begin
                  len_done = 1'b1;
               end
            end
            PH_EXT: begin
               len_in      = new_len;
               ext_left_in = ext_left_ff - 4'd1;
               if (ext_left_ff == 4'd1) begin
                  len_done = 1'b1;
               end
            end
            PH_MASK: begin
               key_in       = {key_ff[23:0], rx_byte};
               mask_left_in = mask_left_ff - 3'd1;
               if (mask_left_ff == 3'd1) begin
                  hdr_done = 1'b1;
               end
            end
            PH_DATA: begin
               len_in   = len_ff - 64'd1;
               idx_in   = idx_ff + 2'd1;
               if (last_byte) begin
                  phase_in = PH_HDR0;
               end
               cmd_push            = 1'b1;
               cmd.event_res       = EV_BYTE;
               cmd.data            = rx_byte;
               cmd.key             = key_byte;
               cmd.frame_kind      = kind_ff;
               cmd.last_of_frame   = last_byte;
               cmd.last_of_message = last_byte & fin_ff;
            end
            default: begin
               fin_in   = rx_byte[7];
               phase_in = PH_HDR1;
               case (rx_byte[3:0])
                  OP_CONT:  kind_in = KIND_CONT;
                  OP_TEXT:  kind_in = KIND_TEXT;
                  OP_BIN:   kind_in = KIND_BIN;
                  OP_PING:  kind_in = KIND_PING;
                  OP_PONG:  kind_in = KIND_PONG;
                  OP_CLOSE: begin
                     phase_in      = PH_HDR0;
                     halted_in     = 1'b1;
                     cmd_push      = 1'b1;
                     cmd.event_res = EV_CLOSE;
                  end
                  default: begin
                     phase_in      = PH_HDR0;
                     halted_in     = 1'b1;
                     cmd_push      = 1'b1;
                     cmd.event_res = EV_BADOP;
                  end
               endcase
            end
         endcase

         if (len_done) begin
            len_in = new_len;
            if (too_long) begin
               halted_in     = 1'b1;
               cmd_push      = 1'b1;
               cmd.event_res = EV_TOOLONG;
            end else begin
               if (is_data) begin
                  acc_in = fin_ff ? 33'd0 : acc_sum[32:0];
               end
               if (server_role) begin
                  mask_left_in = MASK_BYTES;
                  key_in       = '0;
                  phase_in     = PH_MASK;
               end else begin
                  hdr_done = 1'b1;
               end
            end
         end

         if (hdr_done) begin
            idx_in = 2'd0;
            if (len_in == 64'd0) begin
               phase_in = PH_HDR0;
               if (fin_ff) begin
                  cmd_push            = 1'b1;
                  cmd.event_res       = EV_EMPTY;
                  cmd.frame_kind      = kind_ff;
                  cmd.last_of_frame   = 1'b1;
                  cmd.last_of_message = 1'b1;
               end
            end else begin
               phase_in = PH_DATA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         fin_ff       <= 1'b0;
         kind_ff      <= KIND_CONT;
         ext_left_ff  <= '0;
         len_ff       <= '0;
         idx_ff       <= '0;
         key_ff       <= '0;
         mask_left_ff <= '0;
         acc_ff       <= '0;
         halted_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fin_ff       <= fin_in;
         kind_ff      <= kind_in;
         ext_left_ff  <= ext_left_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         key_ff       <= key_in;
         mask_left_ff <= mask_left_in;
         acc_ff       <= acc_in;
         halted_ff    <= halted_in;
      end
   end

   assign stop_ev = cmd_push && (cmd.event_res inside {EV_CLOSE, EV_BADOP, EV_TOOLONG});

   `WFD_ASSERT_NEVER(a_halted_silent, clock, reset, halted_ff && cmd_push)
   `WFD_ASSERT_NEXT(a_stop_event_halts, clock, reset, stop_ev, halted_ff)
   `WFD_ASSERT_NEVER(a_phase_legal, clock, reset, phase_ff > PH_DATA)

endmodule

`default_nettype wire

@@ rtl/wfd_fifo.sv @@
// Short command queue between the header parser and the result stage.
// Depends on wfd_pkg and websocket_frame_decoder_defines.svh.
`default_nettype none
`include "websocket_frame_decoder_defines.svh"

module wfd_fifo
   import wfd_pkg::*;
#(
   parameter int DEPTH = WFD_QUEUE_DEPTH
)
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  wire wfd_cmd_type push_data,
   input  wire logic  pop,
   output wfd_cmd_type pop_data,
   output logic       full,
   output logic       empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   wfd_cmd_type        entries_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `WFD_ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `WFD_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CW'(DEPTH))

endmodule

`default_nettype wire

@@ rtl/wfd_emitter.sv @@
// Back end: unmasks payload bytes and holds the result presented to the consumer.
// Depends on wfd_pkg.
`default_nettype none

module wfd_emitter
   import wfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire wfd_cmd_type cmd,
   input  wire logic        cmd_valid,
   output logic             cmd_pop,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic [2:0]       rsp_event_res,
   output logic [7:0]       rsp_payload_byte,
   output logic [2:0]       rsp_frame_kind,
   output logic             rsp_last_of_frame,
   output logic             rsp_last_of_message
);

   logic       valid_ff, valid_in;
   logic [2:0] event_ff;
   logic [7:0] byte_ff;
   logic [2:0] kind_ff;
   logic       lof_ff;
   logic       lom_ff;
   logic       load;

   assign load     = cmd_valid && (!valid_ff || rsp_pop);
   assign cmd_pop  = load;
   assign valid_in = load ? 1'b1 : (rsp_pop ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         event_ff <= cmd.event_res;
         byte_ff  <= cmd.data ^ cmd.key;
         kind_ff  <= cmd.frame_kind;
         lof_ff   <= cmd.last_of_frame;
         lom_ff   <= cmd.last_of_message;
      end
   end

   assign rsp_empty           = !valid_ff;
   assign rsp_event_res       = event_ff;
   assign rsp_payload_byte    = byte_ff;
   assign rsp_frame_kind      = kind_ff;
   assign rsp_last_of_frame   = lof_ff;
   assign rsp_last_of_message = lom_ff;

endmodule

`default_nettype wire

@@ rtl/websocket_frame_decoder.sv @@
// WebSocket receive deframer: one stream byte per cycle while req_full is low, at most one result per byte.
// A result passes through the command queue and then the result stage register before it reaches the rsp_ ports.
// Throughput: one byte per cycle sustained while req_full is low; req_full rises only when the command queue fills.
// Reset (synchronous, active high) returns the parser to the first header byte, clears the
// halt, empties the queue and result stage, and restores server_role 0, max 65536 bytes.
// Depends on wfd_pkg, wfd_parser, wfd_fifo and wfd_emitter.
`default_nettype none

module websocket_frame_decoder
   import wfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = WFD_QUEUE_DEPTH
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [7:0]             req_rx_byte,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [2:0]                  rsp_event_res,
   output logic [7:0]                  rsp_payload_byte,
   output logic [2:0]                  rsp_frame_kind,
   output logic                        rsp_last_of_frame,
   output logic                        rsp_last_of_message,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_wdata
);

   logic        server_role_ff;
   logic [31:0] max_msg_ff;
   logic        byte_valid;
   wfd_cmd_type front_cmd;
   logic        front_push;
   wfd_cmd_type back_cmd;
   logic        q_empty;
   logic        back_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         server_role_ff <= SERVER_ROLE_RESET;
         max_msg_ff     <= MAX_MSG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SERVER_ROLE: server_role_ff <= csr_wdata[0];
            CSR_MAX_MSG:     max_msg_ff     <= csr_wdata;
            default:         ;
         endcase
      end
   end

   assign byte_valid = req_push && !req_full;

   wfd_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .byte_valid        (byte_valid),
      .rx_byte           (req_rx_byte),
      .server_role       (server_role_ff),
      .max_message_bytes (max_msg_ff),
      .cmd               (front_cmd),
      .cmd_push          (front_push)
   );

   wfd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .pop       (back_pop),
      .pop_data  (back_cmd),
      .full      (req_full),
      .empty     (q_empty)
   );

   wfd_emitter u_emitter (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (back_cmd),
      .cmd_valid           (!q_empty),
      .cmd_pop             (back_pop),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_event_res       (rsp_event_res),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_frame_kind      (rsp_frame_kind),
      .rsp_last_of_frame   (rsp_last_of_frame),
      .rsp_last_of_message (rsp_last_of_message)
   );

endmodule

`default_nettype wire

@@ dv/tb_websocket_frame_decoder.sv @@
// Self-checking testbench for websocket_frame_decoder: a directed table of frames, then random
// well-formed frames over register settings and a halting tail, checked by a built-in frame parser.
// Depends on wfd_pkg and the websocket_frame_decoder RTL.
module tb_websocket_frame_decoder;
   import wfd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_BYTES = 230;
   localparam int NUM_ROWS = 25;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   typedef struct packed {
      logic [2:0] ev;
      logic [7:0] data;
      logic [2:0] kind;
      logic       lof;
      logic       lom;
   } frame_out_type;

   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FIXED} row_check_type;

   typedef struct packed {
      logic [7:0]    rx;
      row_check_type chk;
      frame_out_type res;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [7:0]             req_rx_byte = 8'h00;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [2:0]             rsp_event_res;
   logic [7:0]             rsp_payload_byte;
   logic [2:0]             rsp_frame_kind;
   logic                   rsp_last_of_frame;
   logic                   rsp_last_of_message;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SERVER_ROLE;
   logic [31:0]            csr_wdata = 32'd0;

   websocket_frame_decoder dut (.*);

   always #4 clock = ~clock;

   // parser state
   logic        cfg_server = SERVER_ROLE_RESET;
   logic [31:0] cfg_max = MAX_MSG_RESET;
   logic [2:0]  phase = PH_HDR0;
   logic        fin_seen = 1'b0;
   logic [2:0]  cur_kind = KIND_CONT;
   logic [3:0]  ext_left = 4'd0;
   logic [63:0] flen = 64'd0;
   logic [63:0] pidx = 64'd0;
   logic [31:0] mkey = 32'd0;
   logic [2:0]  mkey_left = 3'd0;
   logic [32:0] msg_total = 33'd0;
   logic        stopped = 1'b0;

   frame_out_type pending_out[$];
   int  errors = 0;
   int  bytes_sent = 0;
   int  cycle_count = 0;
   int  rx_hold_req = 0;
   bit  tx_burst = 1'b0;
   bit  rx_burst = 1'b0;

   stim_row_type dir_rows [NUM_ROWS] = '{
      '{8'h81, CHK_NONE, '0},
      '{8'h02, CHK_NONE, '0},
      '{8'h00, CHK_FIXED, {EV_BYTE, 8'h00, KIND_TEXT, 1'b0, 1'b0}},
      '{8'hFF, CHK_FIXED, {EV_BYTE, 8'hFF, KIND_TEXT, 1'b1, 1'b1}},
      '{8'h89, CHK_NONE, '0},
      '{8'h00, CHK_FIXED, {EV_EMPTY, 8'h00, KIND_PING, 1'b1, 1'b1}},
      '{8'h0A, CHK_NONE, '0},
      '{8'h80, CHK_NONE, '0},     // mask bit set, empty frame without FIN
      '{8'h72, CHK_NONE, '0},     // RSV bits set
      '{8'hFE, CHK_NONE, '0},
      '{8'h00, CHK_NONE, '0},
      '{8'h01, CHK_NONE, '0},
      '{8'hA5, CHK_FIXED, {EV_BYTE, 8'hA5, KIND_BIN, 1'b1, 1'b0}},
      '{8'h80, CHK_NONE, '0},
      '{8'h7F, CHK_NONE, '0},
      '{8'h00, CHK_NONE, '0},
      '{8'h00, CHK_NONE, '0},
      '{8'h00, CHK_NONE, '0},
      '{8'h00, CHK_NONE, '0},
      '{8'h00, CHK_NONE, '0},
      '{8'h00, CHK_NONE, '0},
      '{8'h00, CHK_NONE, '0},
      '{8'h02, CHK_NONE, '0},
      '{8'h5A, CHK_MODEL, '0},
      '{8'hC3, CHK_MODEL, '0}
   };

   function automatic bit halt_with(input logic [2:0] ev, output frame_out_type r);
      stopped = 1'b1;
      r = {ev, 8'h00, KIND_CONT, 1'b0, 1'b0};
      return 1'b1;
   endfunction

   function automatic bit start_payload(output frame_out_type r);
      r = '0;
      pidx = 64'd0;
      if (flen == 64'd0) begin
         phase = PH_HDR0;
         if (fin_seen) begin
            r = {EV_EMPTY, 8'h00, cur_kind, 1'b1, 1'b1};
            return 1'b1;
         end
         return 1'b0;
      end
      phase = PH_DATA;
      return 1'b0;
   endfunction

   function automatic bit finish_length(output frame_out_type r);
      logic [63:0] lim;
      logic [63:0] acc;
      lim = 64'(cfg_max);
      acc = 64'(msg_total);
      r = '0;
      if (cur_kind <= KIND_BIN) begin
         if (acc > lim || flen > lim - acc)
            return halt_with(EV_TOOLONG, r);
         msg_total = fin_seen ? 33'd0 : 33'(acc + flen);
      end else if (flen > lim) begin
         return halt_with(EV_TOOLONG, r);
      end
      if (cfg_server) begin
         mkey_left = MASK_BYTES;
         mkey = 32'd0;
         phase = PH_MASK;
         return 1'b0;
      end
      return start_payload(r);
   endfunction

   // advances the parser by one stream byte; returns 1 when a result is produced
   function automatic bit deframe_byte(input logic [7:0] b, output frame_out_type r);
      logic [7:0] k;
      logic       last;
      int         sh;
      r = '0;
      if (stopped)
         return 1'b0;
      case (phase)
         PH_HDR1: begin
            flen = 64'd0;
            if (b[6:0] >= LEN7_EXT16) begin
               ext_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               phase = PH_EXT;
               return 1'b0;
            end
            flen = 64'(b[6:0]);
            return finish_length(r);
         end
         PH_EXT: begin
            flen = {flen[55:0], b};
            ext_left = ext_left - 4'd1;
            if (ext_left != 4'd0)
               return 1'b0;
            return finish_length(r);
         end
         PH_MASK: begin
            mkey = {mkey[23:0], b};
            mkey_left = mkey_left - 3'd1;
            if (mkey_left != 3'd0)
               return 1'b0;
            return start_payload(r);
         end
         PH_DATA: begin
            k = 8'h00;
            if (cfg_server) begin
               sh = 24 - 8 * int'(pidx[1:0]);
               k = 8'(mkey >> sh);
            end
            pidx = pidx + 64'd1;
            last = (pidx >= flen);
            if (last)
               phase = PH_HDR0;
            r = {EV_BYTE, b ^ k, cur_kind, last, last & fin_seen};
            return 1'b1;
         end
         default: begin
            phase = PH_HDR0;
            fin_seen = b[7];
            case (b[3:0])
               OP_CLOSE: return halt_with(EV_CLOSE, r);
               OP_CONT:  cur_kind = KIND_CONT;
               OP_TEXT:  cur_kind = KIND_TEXT;
               OP_BIN:   cur_kind = KIND_BIN;
               OP_PING:  cur_kind = KIND_PING;
               OP_PONG:  cur_kind = KIND_PONG;
               default:  return halt_with(EV_BADOP, r);
            endcase
            phase = PH_HDR1;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic transfer_byte(input logic [7:0] b, input row_check_type chk,
                                input frame_out_type fixed);
      int            gap;
      bit            got;
      frame_out_type r;
      gap = tx_burst ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 63) == 0)
         tx_burst = ~tx_burst;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      got = deframe_byte(b, r);
      if (chk == CHK_FIXED)
         pending_out = {pending_out, fixed};
      else if (got)
         pending_out = {pending_out, r};
      bytes_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      transfer_byte(b, CHK_MODEL, '0);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic server, input logic [31:0] max_bytes);
      csr_we <= 1'b1;
      csr_index <= CSR_SERVER_ROLE;
      csr_wdata <= 32'(server);
      @(posedge clock);
      cfg_server = server;
      csr_index <= CSR_MAX_MSG;
      csr_wdata <= max_bytes;
      @(posedge clock);
      cfg_max = max_bytes;
      csr_we <= 1'b0;
   endtask

   function automatic logic [3:0] pick_opcode();
      case ($urandom_range(0, 9))
         0, 1:    return OP_CONT;
         2, 3, 4: return OP_TEXT;
         5, 6, 7: return OP_BIN;
         8:       return OP_PING;
         default: return OP_PONG;
      endcase
   endfunction

   // length is encoded in any legal form, minimal or not
   task automatic send_frame(input logic [3:0] op, input logic fin, input longint unsigned len);
      int         form;
      int         n;
      logic [6:0] len7;
      form = $urandom_range(0, 2);
      if (len > 125 && form == 0)
         form = 1;
      if (len > 65535)
         form = 2;
      n = (form == 1) ? 2 : ((form == 2) ? 8 : 0);
      len7 = (form == 0) ? 7'(len) : ((form == 1) ? LEN7_EXT16 : LEN7_EXT64);
      send_byte({fin, 3'($urandom), op});
      send_byte({1'($urandom), len7});
      for (int i = n - 1; i >= 0; i--)
         send_byte(8'(len >> (8 * i)));
      if (cfg_server)
         repeat (MASK_BYTES) send_byte(8'($urandom));
      repeat (len) send_byte(8'($urandom));
   endtask

   task automatic send_random_frame();
      logic [3:0]      op;
      longint unsigned len;
      longint unsigned room;
      int              r;
      op = pick_opcode();
      room = (op == OP_PING || op == OP_PONG) ? 64'(cfg_max) : 64'(cfg_max) - 64'(msg_total);
      r = $urandom_range(0, 15);
      if (r < 3)
         len = 0;
      else if (r < 13)
         len = $urandom_range(1, 16);
      else
         len = $urandom_range(17, 150);
      if (len > room)
         len = room;
      send_frame(op, 1'($urandom), len);
   endtask

   // the block stays halted until reset, so this is the last thing it sees
   task automatic finish_with_halt();
      int         r;
      logic [3:0] op;
      case ($urandom_range(0, 3))
         0: send_byte({1'($urandom), 3'($urandom), OP_CLOSE});
         1: begin
            r = $urandom_range(0, 9);
            op = (r < 5) ? 4'(OP_BIN + 1 + r) : 4'(OP_PONG + r - 4);
            send_byte({1'($urandom), 3'($urandom), op});
         end
         2: begin
            send_byte({1'($urandom), 3'($urandom), pick_opcode()});
            send_byte({1'($urandom), LEN7_EXT64});
            send_byte(8'($urandom_range(1, 255)));
            repeat (7) send_byte(8'($urandom));
         end
         default: begin
            for (int i = 0; i < 400 && !stopped; i++)
               send_byte(8'($urandom));
         end
      endcase
      repeat (12) send_byte(8'($urandom));
   endtask

   initial begin
      int phase_end;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_ROWS; i++)
         transfer_byte(dir_rows[i].rx, dir_rows[i].chk, dir_rows[i].res);
      wait_drained();
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       apply_settings(1'b1, 32'hFFFF_FFFF);
            1:       apply_settings(1'b0, 32'd1);
            2:       apply_settings(1'b1, 32'd1);
            3:       apply_settings(1'b0, 32'd300);
            4:       apply_settings(1'b1, 32'd40);
            default: apply_settings(1'($urandom), $urandom_range(2, 600));
         endcase
         if (p == 0) begin
            // receiver stalls while a long frame backs up the queue
            rx_hold_req = 250;
            send_frame(OP_BIN, 1'b1, 80);
         end
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end)
            send_random_frame();
         send_frame(OP_CONT, 1'b1, 0);
         wait_drained();
      end
      finish_with_halt();
      wait_drained();
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int            wait_n;
      frame_out_type want;
      wait (reset == 1'b0);
      forever begin
         if (rx_hold_req > 0) begin
            wait_n = rx_hold_req;
            rx_hold_req = 0;
         end else begin
            wait_n = rx_burst ? 0 : $urandom_range(0, 4);
         end
         if ($urandom_range(0, 49) == 0)
            rx_burst = ~rx_burst;
         if (wait_n > 0) begin
            rsp_pop <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         if (pending_out.size() == 0) begin
            $error("unexpected transfer: event_res %0d", rsp_event_res);
            errors++;
         end else begin
            want = pending_out.pop_front();
            if (rsp_event_res !== want.ev) begin
               $error("event_res: expected %0d, got %0d", want.ev, rsp_event_res);
               errors++;
            end
            if (rsp_payload_byte !== want.data) begin
               $error("payload_byte: expected %0h, got %0h", want.data, rsp_payload_byte);
               errors++;
            end
            if (rsp_frame_kind !== want.kind) begin
               $error("frame_kind: expected %0d, got %0d", want.kind, rsp_frame_kind);
               errors++;
            end
            if (rsp_last_of_frame !== want.lof) begin
               $error("last_of_frame: expected %0d, got %0d", want.lof, rsp_last_of_frame);
               errors++;
            end
            if (rsp_last_of_message !== want.lom) begin
               $error("last_of_message: expected %0d, got %0d", want.lom, rsp_last_of_message);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

@@ websocket_frame_decoder.f @@
+incdir+rtl
rtl/wfd_pkg.sv
rtl/wfd_parser.sv
rtl/wfd_fifo.sv
rtl/wfd_emitter.sv
rtl/websocket_frame_decoder.sv
dv/tb_websocket_frame_decoder.sv
